// File: design/xor_delta_point_encoder_top_macros.svh
// Assertion macros for the XOR-delta point encoder checker.
// No dependencies; included by the checker file only.
`ifndef XOR_DELTA_POINT_ENCODER_TOP_MACROS_SVH
`define XOR_DELTA_POINT_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XDPE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("xdpe check failed");

// Next-cycle implication, disabled while reset is asserted.
`define XDPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("xdpe check failed");

`endif

// File: design/xdpe_pkg.sv
// Shared types, constants and the bit-length function of the XOR-delta point encoder.
// No dependencies.
`timescale 1ns / 1ps

package xdpe_pkg;

	localparam int CountWidth = 32;
	localparam int CodeWidth = 6;
	localparam int RawWidth = 64;
	localparam int ChunkWidthBits = 7;
	localparam int NumCoords = 3;
	localparam int DefaultQueueDepth = 2;

	// Chunk index of the final beat of a first point and of a later point.
	localparam logic [2:0] LastFirstIdx = 3'd3;
	localparam logic [2:0] LastDeltaIdx = 3'd5;

	typedef logic [RawWidth-1:0] coord_t;
	typedef logic [CodeWidth-1:0] code_t;

	// One classified point: raw patterns for a first point, deltas otherwise.
	typedef struct packed {
		logic first;
		logic [CountWidth-1:0] count;
		logic [NumCoords-1:0][RawWidth-1:0] val;
		logic [NumCoords-1:0][CodeWidth-1:0] code;
	} entry_t;

	// Index of the highest set bit (bit length minus one); zero for a zero word.
	// Two levels of eight: inside each byte, then across the bytes.
	function automatic code_t msb_index(input coord_t v);
		logic [7:0] grp_any;
		logic [7:0][2:0] grp_pos;
		logic [2:0] top;
		grp_any = '0;
		grp_pos = '0;
		top = '0;
		for (int g = 0; g < 8; g++) begin
			grp_any[g] = |v[8*g +: 8];
			for (int b = 0; b < 8; b++) begin
				if (v[8*g + b]) begin
					grp_pos[g] = 3'(b);
				end
			end
		end
		for (int g = 0; g < 8; g++) begin
			if (grp_any[g]) begin
				top = 3'(g);
			end
		end
		return {top, grp_pos[top]};
	endfunction

endpackage

// File: design/xdpe_front.sv
// Front part: accepts points, forms XOR deltas against the previous point and
// measures their bit lengths. Depends on xdpe_pkg.
`timescale 1ns / 1ps

module xdpe_front (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic first_point,
	input  logic [xdpe_pkg::CountWidth-1:0] point_count,
	input  logic [xdpe_pkg::RawWidth-1:0] time_bits,
	input  logic [xdpe_pkg::RawWidth-1:0] lat_bits,
	input  logic [xdpe_pkg::RawWidth-1:0] lon_bits,
	input  logic q_full,
	output logic q_wr,
	output xdpe_pkg::entry_t q_wr_entry
);
	import xdpe_pkg::*;

	coord_t prev_q [NumCoords];
	coord_t cur [NumCoords];
	logic accept;
	logic valid_s1;
	logic first_s1;
	logic [CountWidth-1:0] count_s1;
	coord_t val_s1 [NumCoords];

	assign cur[0] = time_bits;
	assign cur[1] = lat_bits;
	assign cur[2] = lon_bits;

	assign q_wr = valid_s1 && !q_full;
	assign full = valid_s1 && q_full;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int j = 0; j < NumCoords; j++) begin
				prev_q[j] <= '0;
			end
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				for (int j = 0; j < NumCoords; j++) begin
					prev_q[j] <= cur[j];
				end
			end else if (q_wr) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_s1 <= first_point;
			count_s1 <= point_count;
			for (int j = 0; j < NumCoords; j++) begin
				val_s1[j] <= first_point ? cur[j] : (cur[j] ^ prev_q[j]);
			end
		end
	end

	always_comb begin
		q_wr_entry.first = first_s1;
		q_wr_entry.count = count_s1;
		for (int j = 0; j < NumCoords; j++) begin
			q_wr_entry.val[j] = val_s1[j];
			q_wr_entry.code[j] = msb_index(val_s1[j]);
		end
	end

endmodule

// File: design/xdpe_fifo.sv
// Short queue of classified points between the front and back parts.
// Depends on xdpe_pkg.
`timescale 1ns / 1ps

module xdpe_fifo #(
	parameter int Depth = xdpe_pkg::DefaultQueueDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  xdpe_pkg::entry_t wr_entry,
	input  logic rd,
	output xdpe_pkg::entry_t rd_entry,
	output logic q_full,
	output logic q_empty
);
	import xdpe_pkg::*;

	localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntWidth = $clog2(Depth + 1);
	localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);

	entry_t mem_q [Depth];
	logic [PtrWidth-1:0] wr_ptr_q;
	logic [PtrWidth-1:0] rd_ptr_q;
	logic [CntWidth-1:0] cnt_q;

	assign q_full = (cnt_q == CntWidth'(Depth));
	assign q_empty = (cnt_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

// File: design/xdpe_back.sv
// Back part: walks the queue head through its chunks, one beat per cycle while
// each beat is popped, into the result register. Depends on xdpe_pkg.
`timescale 1ns / 1ps

module xdpe_back (
	input  logic clk,
	input  logic arst_n,
	input  xdpe_pkg::entry_t head,
	input  logic q_empty,
	output logic q_rd,
	input  logic pop,
	output logic empty,
	output logic [xdpe_pkg::RawWidth-1:0] chunk_value,
	output logic [xdpe_pkg::ChunkWidthBits-1:0] chunk_width,
	output logic last_chunk
);
	import xdpe_pkg::*;

	logic [2:0] idx_q;
	logic out_valid_q;
	logic load;
	logic [1:0] coord;
	coord_t sel_value;
	logic [ChunkWidthBits-1:0] sel_width;
	logic sel_last;

	assign empty = !out_valid_q;
	assign load = !q_empty && (!out_valid_q || pop);
	assign q_rd = load && sel_last;

	always_comb begin
		if (head.first) begin
			coord = idx_q[1:0] - 2'd1;
			sel_last = (idx_q == LastFirstIdx);
			if (idx_q == 3'd0) begin
				sel_value = RawWidth'(head.count);
				sel_width = ChunkWidthBits'(CountWidth);
			end else begin
				sel_value = head.val[coord];
				sel_width = ChunkWidthBits'(RawWidth);
			end
		end else begin
			coord = idx_q[2:1];
			sel_last = (idx_q == LastDeltaIdx);
			if (!idx_q[0]) begin
				sel_value = RawWidth'(head.code[coord]);
				sel_width = ChunkWidthBits'(CodeWidth);
			end else begin
				// The delta has no bits above its length, so no masking is needed.
				sel_value = head.val[coord];
				sel_width = ChunkWidthBits'(head.code[coord]) + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q <= sel_last ? '0 : idx_q + 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			chunk_value <= sel_value;
			chunk_width <= sel_width;
			last_chunk <= sel_last;
		end
	end

endmodule

// File: design/xor_delta_point_encoder_top.sv
// XOR-delta point encoder: a point passes through the front stage register, the queue and
// the result register before its first beat is on the result ports.
// A later point gives 6 beats and a first point 4, one per cycle from the result register
// while each beat is popped; the back sequencer sets that pace.
// The front takes a new point each cycle while the queue between the parts has room.
// Asynchronous reset clears the previous-point patterns to zero and empties all stages.
`timescale 1ns / 1ps

module xor_delta_point_encoder_top #(
	parameter int QueueDepth = xdpe_pkg::DefaultQueueDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic first_point,
	input  logic [xdpe_pkg::CountWidth-1:0] point_count,
	input  logic [xdpe_pkg::RawWidth-1:0] time_bits,
	input  logic [xdpe_pkg::RawWidth-1:0] lat_bits,
	input  logic [xdpe_pkg::RawWidth-1:0] lon_bits,
	input  logic pop,
	output logic empty,
	output logic [xdpe_pkg::RawWidth-1:0] chunk_value,
	output logic [xdpe_pkg::ChunkWidthBits-1:0] chunk_width,
	output logic last_chunk
);
	import xdpe_pkg::*;

	entry_t wr_entry;
	entry_t head;
	logic q_wr;
	logic q_rd;
	logic q_full;
	logic q_empty;

	xdpe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.first_point (first_point),
		.point_count (point_count),
		.time_bits   (time_bits),
		.lat_bits    (lat_bits),
		.lon_bits    (lon_bits),
		.q_full      (q_full),
		.q_wr        (q_wr),
		.q_wr_entry  (wr_entry)
	);

	xdpe_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wr_entry (wr_entry),
		.rd       (q_rd),
		.rd_entry (head),
		.q_full   (q_full),
		.q_empty  (q_empty)
	);

	xdpe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_empty     (q_empty),
		.q_rd        (q_rd),
		.pop         (pop),
		.empty       (empty),
		.chunk_value (chunk_value),
		.chunk_width (chunk_width),
		.last_chunk  (last_chunk)
	);

endmodule

// File: design/xdpe_checker.sv
// Port-level checks of the XOR-delta point encoder and their bind to the top level.
// Depends on xdpe_pkg and xor_delta_point_encoder_top_macros.svh.
`timescale 1ns / 1ps
`include "xor_delta_point_encoder_top_macros.svh"

module xdpe_checker (
	input logic clk,
	input logic arst_n,
	input logic pop,
	input logic empty,
	input logic [xdpe_pkg::RawWidth-1:0] chunk_value,
	input logic [xdpe_pkg::ChunkWidthBits-1:0] chunk_width,
	input logic last_chunk
);
	import xdpe_pkg::*;

	// A waiting beat stays put until it is taken.
	`XDPE_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(chunk_value) && $stable(chunk_width))

	`XDPE_ASSERT_IMPLY(a_width_range, clk, arst_n, !empty, chunk_width != '0 && chunk_width <= ChunkWidthBits'(RawWidth))

	// No bits stand above the stated width.
	`XDPE_ASSERT_IMPLY(a_value_fits, clk, arst_n, !empty && chunk_width < ChunkWidthBits'(RawWidth), (chunk_value >> chunk_width) == '0)

	// The beats of one point follow each other without a gap.
	`XDPE_ASSERT_NEXT(a_no_gap, clk, arst_n, !empty && pop && !last_chunk, !empty)

endmodule

bind xor_delta_point_encoder_top xdpe_checker u_xdpe_checker (.*);
